@@ rtl/core/lobm_pkg.sv @@
// Shared types, codes and sizes of the limit order book matcher.
package lobm_pkg;

   localparam int PRICE_LEVELS = 1024;
   localparam int ORDER_SLOTS  = 64;
   localparam int LVL_W        = $clog2(PRICE_LEVELS);
   localparam int ID_W         = $clog2(ORDER_SLOTS);
   localparam logic [ID_W-1:0] ID_LIMIT = ID_W'(ORDER_SLOTS - 1);

   localparam logic [1:0] CMD_LIMIT  = 2'd0;
   localparam logic [1:0] CMD_MARKET = 2'd1;
   localparam logic [1:0] CMD_CANCEL = 2'd2;

   localparam logic [1:0] KIND_FILL   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_CANCEL = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LOAD,
      OP_DECIDE,
      OP_HEAD_RD,
      OP_HEAD_TAKE,
      OP_SLOT_CHK,
      OP_SLOT_USE,
      OP_SCAN_STEP,
      OP_PLACE,
      OP_LINK,
      OP_EMIT_INIT,
      OP_FILL_RD,
      OP_FILL_NEXT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   show_final;
   } dp_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic order_ok;
      logic walk_go;
      logic id_zero;
      logic slot_less;
      logic new_head_zero;
      logic scan_end;
      logic scan_hit;
      logic done;
      logic have_fills;
      logic fill_last;
   } dp_status_type;

endpackage

@@ rtl/core/lobm_ctrl.sv @@
// Sequencer of the order book matcher: steps the datapath through each item.
module lobm_ctrl import lobm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output dp_cmd_type    cmd,
   input  dp_status_type sts
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECIDE, S_LCHK, S_HRD, S_HTAKE, S_SCHK, S_SUSE,
      S_SCAN, S_SCANW, S_PLACE, S_LINK, S_EMIT, S_FRD, S_FOUT, S_LAST
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.op         = OP_NONE;
      cmd.show_final = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.op   = OP_DECIDE;
            state_in = sts.order_ok ? S_LCHK : S_LAST;
         end
         S_LCHK: begin
            state_in = sts.walk_go ? S_HRD : S_PLACE;
         end
         S_HRD: begin
            cmd.op   = OP_HEAD_RD;
            state_in = S_HTAKE;
         end
         S_HTAKE: begin
            cmd.op   = OP_HEAD_TAKE;
            state_in = S_SCHK;
         end
         S_SCHK: begin
            cmd.op   = OP_SLOT_CHK;
            state_in = sts.id_zero ? S_SCAN : S_SUSE;
         end
         S_SUSE: begin
            cmd.op = OP_SLOT_USE;
            if (sts.slot_less)          state_in = S_SCHK;
            else if (sts.new_head_zero) state_in = S_SCAN;
            else                        state_in = S_LCHK;
         end
         S_SCAN: begin
            cmd.op   = OP_SCAN_STEP;
            state_in = sts.scan_end ? S_LCHK : S_SCANW;
         end
         S_SCANW: begin
            state_in = sts.scan_hit ? S_LCHK : S_SCAN;
         end
         S_PLACE: begin
            cmd.op   = OP_PLACE;
            state_in = sts.done ? S_EMIT : S_LINK;
         end
         S_LINK: begin
            cmd.op   = OP_LINK;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.op   = OP_EMIT_INIT;
            state_in = sts.have_fills ? S_FRD : S_LAST;
         end
         S_FRD: begin
            cmd.op   = OP_FILL_RD;
            state_in = S_FOUT;
         end
         S_FOUT: begin
            if (!rsp_stall) begin
               cmd.op   = OP_FILL_NEXT;
               state_in = sts.fill_last ? S_LAST : S_FRD;
            end
         end
         S_LAST: begin
            cmd.show_final = 1'b1;
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_FOUT) || (state_ff == S_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/core/lobm_datapath.sv @@
// Book memories, walk registers and result buffer of the order book matcher.
module lobm_datapath import lobm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  dp_cmd_type       cmd,
   output dp_status_type    sts,
   input  logic [1:0]       req_cmd,
   input  logic             req_side,
   input  logic [LVL_W-1:0] req_limit_price,
   input  logic [31:0]      req_quantity,
   input  logic [15:0]      req_trader_id,
   input  logic [31:0]      req_client_ref,
   input  logic [ID_W-1:0]  req_target_id,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_buy_trader,
   output logic [31:0]      rsp_buy_ref,
   output logic [15:0]      rsp_sell_trader,
   output logic [31:0]      rsp_sell_ref,
   output logic [LVL_W-1:0] rsp_fill_price,
   output logic [31:0]      rsp_fill_qty,
   output logic [ID_W-1:0]  rsp_assigned_id,
   output logic [LVL_W-1:0] rsp_top_bid,
   output logic [LVL_W:0]   rsp_top_ask,
   output logic             rsp_last
);

   // Item registers.
   logic [1:0]       cmd_ff;
   logic             buy_ff;
   logic [LVL_W-1:0] price_ff;
   logic [31:0]      q_ff;
   logic [15:0]      trader_ff;
   logic [31:0]      ref_ff;
   logic [ID_W-1:0]  target_ff;
   logic [LVL_W:0]   lvl_ff;
   logic [ID_W-1:0]  id_ff;
   logic             done_ff;
   logic [1:0]       kind_ff;
   logic [ID_W-1:0]  assigned_ff;
   logic [ID_W:0]    nfill_ff;
   logic [ID_W:0]    eidx_ff;
   // Book registers.
   logic [LVL_W-1:0] best_bid_ff;
   logic [LVL_W:0]   best_ask_ff;
   logic [ID_W-1:0]  ids_used_ff;
   logic [LVL_W-1:0] clr_cnt_ff;

   // Memories.
   logic [31:0]     slot_qty_mem    [ORDER_SLOTS];
   logic [15:0]     slot_trader_mem [ORDER_SLOTS];
   logic [31:0]     slot_ref_mem    [ORDER_SLOTS];
   logic [ID_W-1:0] slot_next_mem   [ORDER_SLOTS];
   logic [ID_W-1:0] head_mem        [PRICE_LEVELS];
   logic [ID_W-1:0] tail_mem        [PRICE_LEVELS];
   logic [15:0]     fb_bt_mem       [ORDER_SLOTS];
   logic [31:0]     fb_br_mem       [ORDER_SLOTS];
   logic [15:0]     fb_st_mem       [ORDER_SLOTS];
   logic [31:0]     fb_sr_mem       [ORDER_SLOTS];
   logic [31:0]     fb_qty_mem      [ORDER_SLOTS];

   logic [31:0]     sq_q;
   logic [15:0]     st_q;
   logic [31:0]     sr_q;
   logic [ID_W-1:0] sn_q;
   logic [ID_W-1:0] head_q;
   logic [ID_W-1:0] tail_q;
   logic [15:0]     fb_bt_q;
   logic [31:0]     fb_br_q;
   logic [15:0]     fb_st_q;
   logic [31:0]     fb_sr_q;
   logic [31:0]     fb_qty_q;

   // Decisions.
   logic            is_cancel, cancel_ok, order_ok, price_ok, walk_go;
   logic            slot_less, slot_more;
   logic [31:0]     amt;
   logic [ID_W-1:0] new_head;
   logic [LVL_W:0]  scan_lvl;
   logic            scan_end;
   logic [ID_W-1:0] next_id;

   assign is_cancel = (cmd_ff == CMD_CANCEL);
   assign cancel_ok = (target_ff != '0) && (target_ff <= ids_used_ff);
   assign next_id   = ids_used_ff + ID_W'(1);

   always_comb begin
      if (cmd_ff == CMD_MARKET) begin
         price_ok = buy_ff ? !best_ask_ff[LVL_W] : (best_bid_ff != '0);
      end else begin
         price_ok = (price_ff != '0);
      end
   end

   assign order_ok = (cmd_ff == CMD_LIMIT || cmd_ff == CMD_MARKET)
                     && (ids_used_ff < ID_LIMIT) && price_ok;

   assign walk_go = !done_ff && (buy_ff ?
                    ((lvl_ff <= {1'b0, price_ff}) && !lvl_ff[LVL_W]) :
                    ((lvl_ff >= {1'b0, price_ff}) && (lvl_ff != '0)));

   assign slot_less = (sq_q < q_ff);
   assign slot_more = (sq_q > q_ff);
   assign amt       = slot_less ? sq_q : q_ff;
   assign new_head  = slot_more ? id_ff : sn_q;

   assign scan_lvl  = buy_ff ? (lvl_ff + (LVL_W+1)'(1)) : (lvl_ff - (LVL_W+1)'(1));
   assign scan_end  = buy_ff ? scan_lvl[LVL_W] : (scan_lvl == '0);

   always_comb begin
      sts.clear_last    = (clr_cnt_ff == '1);
      sts.order_ok      = !is_cancel && order_ok;
      sts.walk_go       = walk_go;
      sts.id_zero       = (id_ff == '0);
      sts.slot_less     = slot_less;
      sts.new_head_zero = (new_head == '0);
      sts.scan_end      = scan_end;
      sts.scan_hit      = (head_q != '0);
      sts.done          = done_ff;
      sts.have_fills    = (nfill_ff != '0);
      sts.fill_last     = ((eidx_ff + (ID_W+1)'(1)) == nfill_ff);
   end

   // Memory port selection.
   logic             sq_we;
   logic [ID_W-1:0]  sq_wa;
   logic [31:0]      sq_wd;
   logic             sn_we;
   logic [ID_W-1:0]  sn_wa;
   logic [ID_W-1:0]  sn_wd;
   logic             sx_we;
   logic             hd_we;
   logic [LVL_W-1:0] hd_wa;
   logic [ID_W-1:0]  hd_wd;
   logic             hd_re;
   logic [LVL_W-1:0] hd_ra;
   logic             tl_we;
   logic             fb_we;

   always_comb begin
      sq_we = 1'b0; sq_wa = id_ff; sq_wd = '0;
      sn_we = 1'b0; sn_wa = next_id; sn_wd = '0;
      sx_we = 1'b0;
      hd_we = 1'b0; hd_wa = lvl_ff[LVL_W-1:0]; hd_wd = '0;
      hd_re = 1'b0; hd_ra = lvl_ff[LVL_W-1:0];
      tl_we = 1'b0;
      fb_we = 1'b0;
      case (cmd.op)
         OP_CLEAR: begin
            hd_we = 1'b1;
            hd_wa = clr_cnt_ff;
         end
         OP_DECIDE: begin
            if (is_cancel && cancel_ok) begin
               sq_we = 1'b1;
               sq_wa = target_ff;
            end
         end
         OP_HEAD_RD: begin
            hd_re = 1'b1;
         end
         OP_SLOT_CHK: begin
            if (id_ff == '0) hd_we = 1'b1;
         end
         OP_SLOT_USE: begin
            fb_we = (amt != '0);
            if (!slot_less) begin
               hd_we = 1'b1;
               hd_wd = new_head;
               if (slot_more) begin
                  sq_we = 1'b1;
                  sq_wd = sq_q - q_ff;
               end
            end
         end
         OP_SCAN_STEP: begin
            hd_re = 1'b1;
            hd_ra = scan_lvl[LVL_W-1:0];
         end
         OP_PLACE: begin
            hd_re = 1'b1;
            hd_ra = price_ff;
            if (!done_ff) begin
               sq_we = 1'b1; sq_wa = next_id; sq_wd = q_ff;
               sn_we = 1'b1;
               sx_we = 1'b1;
            end
         end
         OP_LINK: begin
            tl_we = 1'b1;
            if (head_q == '0) begin
               hd_we = 1'b1;
               hd_wa = price_ff;
               hd_wd = ids_used_ff;
            end else begin
               sn_we = 1'b1;
               sn_wa = tail_q;
               sn_wd = ids_used_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (sq_we) slot_qty_mem[sq_wa] <= sq_wd;
      sq_q <= slot_qty_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (sx_we) begin
         slot_trader_mem[next_id] <= trader_ff;
         slot_ref_mem[next_id]    <= ref_ff;
      end
      st_q <= slot_trader_mem[id_ff];
      sr_q <= slot_ref_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (sn_we) slot_next_mem[sn_wa] <= sn_wd;
      sn_q <= slot_next_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (hd_we) head_mem[hd_wa] <= hd_wd;
      if (hd_re) head_q <= head_mem[hd_ra];
   end

   always_ff @(posedge clock) begin
      if (tl_we) tail_mem[price_ff] <= ids_used_ff;
      if (hd_re) tail_q <= tail_mem[hd_ra];
   end

   always_ff @(posedge clock) begin
      if (fb_we) begin
         fb_bt_mem[nfill_ff[ID_W-1:0]]  <= buy_ff ? trader_ff : st_q;
         fb_br_mem[nfill_ff[ID_W-1:0]]  <= buy_ff ? ref_ff : sr_q;
         fb_st_mem[nfill_ff[ID_W-1:0]]  <= buy_ff ? st_q : trader_ff;
         fb_sr_mem[nfill_ff[ID_W-1:0]]  <= buy_ff ? sr_q : ref_ff;
         fb_qty_mem[nfill_ff[ID_W-1:0]] <= amt;
      end
      if (cmd.op == OP_FILL_RD) begin
         fb_bt_q  <= fb_bt_mem[eidx_ff[ID_W-1:0]];
         fb_br_q  <= fb_br_mem[eidx_ff[ID_W-1:0]];
         fb_st_q  <= fb_st_mem[eidx_ff[ID_W-1:0]];
         fb_sr_q  <= fb_sr_mem[eidx_ff[ID_W-1:0]];
         fb_qty_q <= fb_qty_mem[eidx_ff[ID_W-1:0]];
      end
   end

   // Book registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         best_bid_ff <= '0;
         best_ask_ff <= (LVL_W+1)'(PRICE_LEVELS);
         ids_used_ff <= '0;
         clr_cnt_ff  <= '0;
      end else begin
         case (cmd.op)
            OP_CLEAR: clr_cnt_ff <= clr_cnt_ff + LVL_W'(1);
            OP_PLACE: begin
               ids_used_ff <= next_id;
               if (buy_ff) best_ask_ff <= lvl_ff;
               else        best_bid_ff <= lvl_ff[LVL_W-1:0];
            end
            OP_LINK: begin
               if (buy_ff) begin
                  if (price_ff > best_bid_ff) best_bid_ff <= price_ff;
               end else begin
                  if ({1'b0, price_ff} < best_ask_ff) best_ask_ff <= {1'b0, price_ff};
               end
            end
            default: ;
         endcase
      end
   end

   // Item registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cmd_ff      <= req_cmd;
            buy_ff      <= !req_side;
            price_ff    <= req_limit_price;
            q_ff        <= req_quantity;
            trader_ff   <= req_trader_id;
            ref_ff      <= req_client_ref;
            target_ff   <= req_target_id;
            done_ff     <= 1'b0;
            nfill_ff    <= '0;
            assigned_ff <= '0;
         end
         OP_DECIDE: begin
            if (is_cancel) begin
               kind_ff <= cancel_ok ? KIND_CANCEL : KIND_REJECT;
            end else if (!order_ok) begin
               kind_ff <= KIND_REJECT;
            end else begin
               kind_ff <= KIND_ACCEPT;
               if (cmd_ff == CMD_MARKET) begin
                  price_ff <= buy_ff ? best_ask_ff[LVL_W-1:0] : best_bid_ff;
               end
               lvl_ff <= buy_ff ? best_ask_ff : {1'b0, best_bid_ff};
            end
         end
         OP_HEAD_TAKE: id_ff <= head_q;
         OP_SLOT_USE: begin
            if (amt != '0) nfill_ff <= nfill_ff + (ID_W+1)'(1);
            if (slot_less) begin
               q_ff  <= q_ff - sq_q;
               id_ff <= sn_q;
            end else begin
               q_ff    <= '0;
               done_ff <= 1'b1;
            end
         end
         OP_SCAN_STEP: lvl_ff <= scan_lvl;
         OP_PLACE:     assigned_ff <= next_id;
         OP_EMIT_INIT: eidx_ff <= '0;
         OP_FILL_NEXT: eidx_ff <= eidx_ff + (ID_W+1)'(1);
         default: ;
      endcase
   end

   // Result fields; the book tops are final once results go out.
   assign rsp_kind        = cmd.show_final ? kind_ff : KIND_FILL;
   assign rsp_buy_trader  = cmd.show_final ? '0 : fb_bt_q;
   assign rsp_buy_ref     = cmd.show_final ? '0 : fb_br_q;
   assign rsp_sell_trader = cmd.show_final ? '0 : fb_st_q;
   assign rsp_sell_ref    = cmd.show_final ? '0 : fb_sr_q;
   assign rsp_fill_price  = cmd.show_final ? '0 : price_ff;
   assign rsp_fill_qty    = cmd.show_final ? '0 : fb_qty_q;
   assign rsp_assigned_id = (cmd.show_final && kind_ff == KIND_ACCEPT) ? assigned_ff : '0;
   assign rsp_top_bid     = best_bid_ff;
   assign rsp_top_ask     = best_ask_ff;
   assign rsp_last        = cmd.show_final;

endmodule

@@ rtl/core/limit_order_book_matcher_top.sv @@
// Top level of the single-symbol price-time priority order book matcher.
//
// The request channel (req_valid / req_stall) carries one command per transfer:
// a limit order, a market order or a cancel. The response channel (rsp_valid /
// rsp_stall) returns the fills of that command in the order they happened,
// followed by one final transfer (rsp_last high) that reports accept, cancel
// done or reject. Every response of a command carries the best bid and best
// ask as they stand after the whole command.
// Items are handled one at a time. A cancel or reject goes from the decide
// state straight to its final response. An order is decided, then at each
// visited price level reads the level head and takes its resting entries in
// turn, searching on for the next best price when a level's queue runs out
// and stepping over empty levels; it then places the order, links a resting
// remainder and starts the results, and sends each fill and then the final
// response.
// After reset the level head memory is cleared one level per cycle, every
// price level in turn; req_stall stays high until it is done.
// A response is held stable while rsp_stall is high, and no new request is
// taken until the final response of the current one has been transferred.
module limit_order_book_matcher_top import lobm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [1:0]       req_cmd,
   input  logic             req_side,
   input  logic [LVL_W-1:0] req_limit_price,
   input  logic [31:0]      req_quantity,
   input  logic [15:0]      req_trader_id,
   input  logic [31:0]      req_client_ref,
   input  logic [ID_W-1:0]  req_target_id,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [15:0]      rsp_buy_trader,
   output logic [31:0]      rsp_buy_ref,
   output logic [15:0]      rsp_sell_trader,
   output logic [31:0]      rsp_sell_ref,
   output logic [LVL_W-1:0] rsp_fill_price,
   output logic [31:0]      rsp_fill_qty,
   output logic [ID_W-1:0]  rsp_assigned_id,
   output logic [LVL_W-1:0] rsp_top_bid,
   output logic [LVL_W:0]   rsp_top_ask,
   output logic             rsp_last
);

   // Commands flow from the sequencer to the datapath, status flows back.
   dp_cmd_type    dp_cmd;
   dp_status_type dp_sts;

   lobm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   // The datapath holds the book memories and buffers the fills of the
   // current command so that they leave with the final best prices.
   lobm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .sts             (dp_sts),
      .req_cmd         (req_cmd),
      .req_side        (req_side),
      .req_limit_price (req_limit_price),
      .req_quantity    (req_quantity),
      .req_trader_id   (req_trader_id),
      .req_client_ref  (req_client_ref),
      .req_target_id   (req_target_id),
      .rsp_kind        (rsp_kind),
      .rsp_buy_trader  (rsp_buy_trader),
      .rsp_buy_ref     (rsp_buy_ref),
      .rsp_sell_trader (rsp_sell_trader),
      .rsp_sell_ref    (rsp_sell_ref),
      .rsp_fill_price  (rsp_fill_price),
      .rsp_fill_qty    (rsp_fill_qty),
      .rsp_assigned_id (rsp_assigned_id),
      .rsp_top_bid     (rsp_top_bid),
      .rsp_top_ask     (rsp_top_ask),
      .rsp_last        (rsp_last)
   );

endmodule
